// ----- hdl/decimal_string_to_fixed_point_top_macros.svh -----
// Assertion helpers used by the top-level module.
`ifndef DECIMAL_STRING_TO_FIXED_POINT_TOP_MACROS_SVH
`define DECIMAL_STRING_TO_FIXED_POINT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DS2FX_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ds2fx check failed");

// Next-cycle implication, checked outside reset.
`define DS2FX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ds2fx check failed");

`endif

// ----- hdl/ds2fx_pkg.sv -----
package ds2fx_pkg;

  localparam int FRAC_W = 30;

  typedef logic [3:0]        places_t;
  typedef logic [FRAC_W-1:0] frac_t;

  localparam places_t MAX_PLACES   = 4'd9;
  localparam places_t PLACES_RESET = 4'd3;

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_COMMA = 16'h002C;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;

  // flags that travel with a finished number
  typedef struct packed {
    logic sat;
    logic neg;
  } fin_flags_t;

  // load enables of the two back-end stages
  typedef struct packed {
    logic ld3;
    logic ld4;
  } stage_ctl_t;

  function automatic frac_t pow10(input places_t e);
    frac_t r;
    case (e)
      4'd0:    r = frac_t'(1);
      4'd1:    r = frac_t'(10);
      4'd2:    r = frac_t'(100);
      4'd3:    r = frac_t'(1000);
      4'd4:    r = frac_t'(10000);
      4'd5:    r = frac_t'(100000);
      4'd6:    r = frac_t'(1000000);
      4'd7:    r = frac_t'(10000000);
      4'd8:    r = frac_t'(100000000);
      4'd9:    r = frac_t'(1000000000);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/decimal_string_to_fixed_point_top.sv -----
// Decimal text to fixed-point converter.
// Input stream s_*: one 16-bit character per item in s_tdata, s_tlast on the
// final character of a number. Output stream m_*: one item per number, the
// signed value times 10^places in m_tdata, overflow flag in m_tuser.
// cfg_*: writes the place count (0..9, larger codes act as 9, reset 3);
// write it only while no number is in flight. cfg_ready is always high.
// Throughput: one character per cycle, including back-to-back numbers, as
// long as the back end can take each last character; each character costs
// one add-and-compare per scaled lane. A finished number passes the input
// register, lane select, add/saturate and sign stage before it is output.
// Reset (rst, synchronous) empties the pipeline, clears the parser and sets
// the place count back to 3.
// When the receiver stalls, finished numbers wait in the back-end stages and
// characters of the next number keep flowing; input stalls only when a last
// character reaches a full back end.
// Saturation: results beyond VALUE_WIDTH-bit signed range clamp and set
// overflow; fixed_value carries the low 32 bits.
`include "decimal_string_to_fixed_point_top_macros.svh"

module decimal_string_to_fixed_point_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] char_code
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] fixed_value
  output logic [0:0]  m_tuser,   // [0] overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data   // [3:0] decimal_places
);
  import ds2fx_pkg::*;

  localparam int EW = ((VALUE_WIDTH > 34) ? VALUE_WIDTH : 34) + 4;
  localparam logic [EW-1:0] SAT_NEG = EW'(0) - (EW'(1) << (VALUE_WIDTH - 1));
  localparam logic [EW-1:0] SAT_POS = (EW'(1) << (VALUE_WIDTH - 1)) - EW'(1);

  places_t decimal_places;
  places_t places;

  // input register
  logic        s1_valid;
  logic [15:0] s1_char;
  logic        s1_last;

  // selected lanes of a finished number
  logic                   s2_valid;
  logic [VALUE_WIDTH-1:0] s2_int;
  frac_t                  s2_frac;
  fin_flags_t             s2_flags;

  logic                   s3_valid;

  logic [VALUE_WIDTH-1:0] fin_int;
  frac_t                  fin_frac;
  fin_flags_t             fin_flags;
  stage_ctl_t             ctl;

  logic free2;
  logic free3;
  logic free4;
  logic adv2;
  logic adv3;
  logic take1;
  logic [31:0] fixed_value;
  logic        overflow;

  assign cfg_ready = 1'b1;
  assign places    = (decimal_places > MAX_PLACES) ? MAX_PLACES : decimal_places;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_places <= PLACES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      decimal_places <= cfg_data;
    end
  end

  // Only last characters move past the parser; the rest retire at once.
  assign free4    = !m_tvalid || m_tready;
  assign adv3     = s3_valid && free4;
  assign free3    = !s3_valid || free4;
  assign adv2     = s2_valid && free3;
  assign free2    = !s2_valid || free3;
  assign take1    = s1_valid && (!s1_last || free2);
  assign s_tready = !s1_valid || take1;
  assign ctl.ld3  = adv2;
  assign ctl.ld4  = adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      s1_valid <= (s_tvalid && s_tready) || (s1_valid && !take1);
      s2_valid <= (take1 && s1_last) || (s2_valid && !adv2);
      s3_valid <= adv2 || (s3_valid && !adv3);
      m_tvalid <= adv3 || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_char <= s_tdata;
      s1_last <= s_tlast;
    end
    if (take1 && s1_last) begin
      s2_int   <= fin_int;
      s2_frac  <= fin_frac;
      s2_flags <= fin_flags;
    end
  end

  ds2fx_parse #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take1),
    .last      (s1_last),
    .char_code (s1_char),
    .places    (places),
    .fin_int   (fin_int),
    .fin_frac  (fin_frac),
    .fin_flags (fin_flags)
  );

  ds2fx_final #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_final (
    .clk         (clk),
    .ctl         (ctl),
    .fin_int     (s2_int),
    .fin_frac    (s2_frac),
    .fin_flags   (s2_flags),
    .fixed_value (fixed_value),
    .overflow    (overflow)
  );

  assign m_tdata    = fixed_value;
  assign m_tuser[0] = overflow;

  // overflowed results sit exactly on a range limit
  `DS2FX_ASSERT_IMPLY(a_ovf_limit, clk, rst, m_tvalid && m_tuser[0], (m_tdata == SAT_POS[31:0]) || (m_tdata == SAT_NEG[31:0]))
  // a last character always lands in the lane-select stage
  `DS2FX_ASSERT_NEXT(a_last_to_s2, clk, rst, take1 && s1_last, s2_valid)
  // input back-pressure comes only from a last character facing a full back end
  `DS2FX_ASSERT_IMPLY(a_stall_cause, clk, rst, !s_tready, s1_valid && s1_last && s2_valid && s3_valid)

endmodule

// ----- hdl/ds2fx_parse.sv -----
// Character parser. Keeps the integer part pre-scaled by 10^q for every
// place count q, and the fraction as the value of its first q digits,
// so the final number is a lane select plus one add.
module ds2fx_parse #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic                     last,
  input  logic [15:0]              char_code,
  input  ds2fx_pkg::places_t       places,
  output logic [VALUE_WIDTH-1:0]   fin_int,
  output ds2fx_pkg::frac_t         fin_frac,
  output ds2fx_pkg::fin_flags_t    fin_flags
);
  import ds2fx_pkg::*;

  localparam int EW    = ((VALUE_WIDTH > 34) ? VALUE_WIDTH : 34) + 4;
  localparam int LANES = int'(MAX_PLACES) + 1;
  localparam logic [EW-1:0] MAG_LIMIT = EW'(1) << (VALUE_WIDTH - 1);

  logic [VALUE_WIDTH-1:0] lane_int      [LANES];
  logic [VALUE_WIDTH-1:0] lane_int_next [LANES];
  logic [LANES-1:0]       lane_sat;
  logic [LANES-1:0]       lane_sat_next;
  frac_t                  lane_frac      [1:LANES-1];
  frac_t                  lane_frac_next [1:LANES-1];
  places_t                cnt;
  places_t                cnt_next;
  logic                   in_frac;
  logic                   in_frac_next;
  logic                   negative;
  logic                   negative_next;
  logic                   stopped;
  logic                   stopped_next;

  logic [3:0]    digit;
  logic          is_digit;
  logic          is_blank;
  logic          is_point;
  logic [EW-1:0] wide_int [LANES];
  logic [LANES-1:0] over;
  frac_t         frac_add [1:LANES-1];

  assign digit    = char_code[3:0];
  assign is_digit = char_code inside {[CH_ZERO:CH_NINE]};
  assign is_blank = char_code inside {CH_SPACE, CH_TAB};
  assign is_point = char_code inside {CH_DOT, CH_COMMA};

  // integer lanes: v*10 + d*10^q, flagged once past 2^(W-1)
  for (genvar q = 0; q < LANES; q++) begin : g_int
    logic [EW-1:0] base;
    assign base        = EW'(lane_int[q]);
    assign wide_int[q] = (base << 3) + (base << 1) +
                         EW'(digit) * EW'(pow10(places_t'(q)));
    assign over[q]     = wide_int[q] > MAG_LIMIT;
  end

  // fraction lanes: new digit at position cnt weighs 10^(q-1-cnt)
  for (genvar q = 1; q < LANES; q++) begin : g_frac
    places_t e;
    assign e           = places_t'(q - 1) - cnt;
    assign frac_add[q] = lane_frac[q] + frac_t'(frac_t'(digit) * pow10(e));
  end

  always_comb begin
    lane_int_next  = lane_int;
    lane_sat_next  = lane_sat;
    lane_frac_next = lane_frac;
    cnt_next       = cnt;
    in_frac_next   = in_frac;
    negative_next  = negative;
    stopped_next   = stopped;
    if (!stopped) begin
      if (char_code == CH_MINUS) begin
        negative_next = 1'b1;
      end else if (is_point) begin
        if (in_frac) begin
          stopped_next = 1'b1;
        end else begin
          in_frac_next = 1'b1;
          cnt_next     = '0;
        end
      end else if (is_digit) begin
        if (!in_frac) begin
          for (int q = 0; q < LANES; q++) begin
            lane_int_next[q] = wide_int[q][VALUE_WIDTH-1:0];
          end
          lane_sat_next = lane_sat | over;
        end else if (cnt < places) begin
          for (int q = 1; q < LANES; q++) begin
            if (places_t'(q) > cnt) begin
              lane_frac_next[q] = frac_add[q];
            end
          end
          cnt_next = cnt + places_t'(1);
        end
      end else if (!is_blank) begin
        stopped_next = 1'b1;
      end
    end
  end

  // pick the lanes for the current place count
  always_comb begin
    fin_int       = lane_int_next[places];
    fin_flags.sat = lane_sat_next[places];
    fin_flags.neg = negative_next;
    fin_frac      = '0;
    for (int q = 1; q < LANES; q++) begin
      if (places == places_t'(q)) begin
        fin_frac = lane_frac_next[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      for (int q = 0; q < LANES; q++) begin
        lane_int[q] <= '0;
      end
      for (int q = 1; q < LANES; q++) begin
        lane_frac[q] <= '0;
      end
      lane_sat <= '0;
      cnt      <= '0;
      in_frac  <= 1'b0;
      negative <= 1'b0;
      stopped  <= 1'b0;
    end else if (take) begin
      lane_int  <= lane_int_next;
      lane_frac <= lane_frac_next;
      lane_sat  <= lane_sat_next;
      cnt       <= cnt_next;
      in_frac   <= in_frac_next;
      negative  <= negative_next;
      stopped   <= stopped_next;
    end
  end

endmodule

// ----- hdl/ds2fx_final.sv -----
// Back end: add fraction, saturate, then apply the sign.
module ds2fx_final #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  ds2fx_pkg::stage_ctl_t  ctl,
  input  logic [VALUE_WIDTH-1:0] fin_int,
  input  ds2fx_pkg::frac_t       fin_frac,
  input  ds2fx_pkg::fin_flags_t  fin_flags,
  output logic [31:0]            fixed_value,
  output logic                   overflow
);
  import ds2fx_pkg::*;

  localparam int EW = ((VALUE_WIDTH > 34) ? VALUE_WIDTH : 34) + 4;
  localparam logic [EW-1:0] LIM_NEG = EW'(1) << (VALUE_WIDTH - 1);
  localparam logic [EW-1:0] LIM_POS = LIM_NEG - EW'(1);

  logic [EW-1:0] sum;
  logic [EW-1:0] lim;
  logic          ovf;
  logic [EW-1:0] mag3;
  logic          ovf3;
  logic          neg3;
  logic [EW-1:0] neg_mag;

  assign sum     = EW'(fin_int) + EW'(fin_frac);
  assign lim     = fin_flags.neg ? LIM_NEG : LIM_POS;
  assign ovf     = fin_flags.sat || (sum > lim);
  assign neg_mag = EW'(0) - mag3;

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      mag3 <= ovf ? lim : sum;
      ovf3 <= ovf;
      neg3 <= fin_flags.neg;
    end
    if (ctl.ld4) begin
      fixed_value <= neg3 ? neg_mag[31:0] : mag3[31:0];
      overflow    <= ovf3;
    end
  end

endmodule
